FILE: sv/mhpq_pkg.sv
package mhpq_pkg;

	localparam int NODE_W = 24;
	localparam int PRIO_W = 32;
	localparam int OCC_W  = 9;

	typedef enum logic [1:0] {
		FUNC_INSERT   = 2'd0,
		FUNC_REMOVE   = 2'd1,
		FUNC_CONTAINS = 2'd2,
		FUNC_UPDATE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_RM_RD,
		S_RM_LAST,
		S_DN_RD,
		S_DN_LEFT,
		S_DN_RIGHT,
		S_FIND_CMP,
		S_FIND_UP,
		S_DONE
	} state_t;

endpackage

FILE: sv/mhpq_ram.sv
module mhpq_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/min_heap_priority_queue_core.sv
// Binary min-heap of (node id, priority) pairs held in one RAM with a registered read.
// One operation runs at a time; busy is high from the cycle after start is taken
// until the result strobe, and the next start is taken in the cycle after done.
// A rejected operation (insert when full, remove or update when empty) goes
// to S_DONE. Insert raises the new entry one level per S_UP_RD and S_UP_CMP pass;
// remove reads the root and the last entry, then sinks that entry through S_DN_RD,
// S_DN_LEFT and S_DN_RIGHT per level. Contains and update walk the entries in
// pre-order, visiting each entry and climbing back; update then adds its up-bubble.
// Every step is bound by the single RAM read port. The result
// is shown for one cycle on done and the receiver cannot stall it.
module min_heap_priority_queue_core #(
	parameter int CAPACITY = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  func,
	input  logic [mhpq_pkg::NODE_W-1:0] node_id,
	input  logic [mhpq_pkg::PRIO_W-1:0] priority_req,
	output logic                        done,
	output logic [mhpq_pkg::NODE_W-1:0] out_node_id,
	output logic [mhpq_pkg::PRIO_W-1:0] out_priority,
	output logic                        found,
	output logic [1:0]                  status,
	output logic [mhpq_pkg::OCC_W-1:0]  occupancy
);
	import mhpq_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = CW + 1;
	localparam int EW = NODE_W + PRIO_W;

	state_t state_q, state_d;

	logic [CW-1:0]     count_q;
	logic [IW-1:0]     idx_q;    // hole or search position, room for 2i+2
	logic [NODE_W-1:0] cur_node_q, onode_q, bnode_q;
	logic [PRIO_W-1:0] cur_prio_q, oprio_q, bprio_q;
	logic              bsel_q;   // smaller of left child and moving entry is the child
	logic              found_q;
	status_t           status_q;
	func_t             func_q;

	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic [EW-1:0]     wdata, rdata;
	logic [NODE_W-1:0] rd_node;
	logic [PRIO_W-1:0] rd_prio;

	assign rd_node = rdata[EW-1:PRIO_W];
	assign rd_prio = rdata[PRIO_W-1:0];

	mhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [IW-1:0] parent, lchild, rchild, sibling, cnt_ext;
	logic          has_left, has_right, hit, climb_next;
	assign cnt_ext    = IW'(count_q);
	assign parent     = (idx_q - IW'(1)) >> 1;
	assign lchild     = {idx_q[IW-2:0], 1'b1};
	assign rchild     = lchild + IW'(1);
	assign sibling    = idx_q + IW'(1);
	assign has_left   = lchild < cnt_ext;
	assign has_right  = rchild < cnt_ext;
	assign hit        = (rd_node == cur_node_q);
	// left subtree done: move to the right sibling if it exists, else climb
	assign climb_next = idx_q[0] && (sibling < cnt_ext);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) begin
				unique case (func_t'(func))
					FUNC_INSERT:
						state_d = (count_q >= CW'(CAPACITY)) ? S_DONE : S_UP_RD;
					FUNC_REMOVE:
						state_d = (count_q == '0) ? S_DONE : S_RM_RD;
					default:
						state_d = (count_q == '0) ? S_DONE : S_FIND_CMP;
				endcase
			end
			S_UP_RD:    state_d = (idx_q == '0) ? S_DONE : S_UP_CMP;
			S_UP_CMP:   state_d = (rd_prio > cur_prio_q) ? S_UP_RD : S_DONE;
			S_RM_RD:    state_d = S_RM_LAST;
			S_RM_LAST:  state_d = S_DN_RD;
			S_DN_RD:    state_d = has_left ? S_DN_LEFT : S_DONE;
			S_DN_LEFT: begin
				if (has_right) state_d = S_DN_RIGHT;
				else state_d = (rd_prio < cur_prio_q) ? S_DN_RD : S_DONE;
			end
			S_DN_RIGHT: state_d = (rd_prio < bprio_q || bsel_q) ? S_DN_RD : S_DONE;
			S_FIND_CMP: begin
				if (hit) state_d = (func_q == FUNC_UPDATE) ? S_UP_RD : S_DONE;
				else if (has_left) state_d = S_FIND_CMP;
				else state_d = S_FIND_UP;
			end
			S_FIND_UP: begin
				if (idx_q == '0) state_d = S_DONE;
				else if (climb_next) state_d = S_FIND_CMP;
				else state_d = S_FIND_UP;
			end
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = {cur_node_q, cur_prio_q};
		raddr = idx_q[AW-1:0];
		unique case (state_q)
			S_IDLE:  raddr = '0;
			S_UP_RD: begin
				if (idx_q == '0) we = 1'b1;
				else raddr = parent[AW-1:0];
			end
			S_UP_CMP: begin
				// move parent down into the hole, or settle the entry here
				we = 1'b1;
				if (rd_prio > cur_prio_q) wdata = rdata;
			end
			S_RM_RD: raddr = AW'(count_q - CW'(1));
			S_DN_RD: begin
				if (has_left) raddr = lchild[AW-1:0];
				else we = 1'b1;
			end
			S_DN_LEFT: begin
				if (has_right) begin
					raddr = rchild[AW-1:0];
				end else begin
					we = 1'b1;
					if (rd_prio < cur_prio_q) wdata = rdata;
				end
			end
			S_DN_RIGHT: begin
				we = 1'b1;
				if (rd_prio < bprio_q) wdata = rdata;
				else if (bsel_q) wdata = {bnode_q, bprio_q};
			end
			S_FIND_CMP: if (!hit && has_left) raddr = lchild[AW-1:0];
			S_FIND_UP:  if (idx_q != '0 && climb_next) raddr = sibling[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start && func_t'(func) == FUNC_INSERT
			    && count_q < CW'(CAPACITY))
				count_q <= count_q + CW'(1);
			else if (state_q == S_RM_RD)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (start) begin
				func_q     <= func_t'(func);
				cur_node_q <= node_id;
				cur_prio_q <= priority_req;
				idx_q      <= (func_t'(func) == FUNC_INSERT) ? IW'(count_q) : '0;
				onode_q    <= '0;
				oprio_q    <= '0;
				found_q    <= 1'b0;
				status_q   <= ST_OK;
				unique case (func_t'(func))
					FUNC_INSERT: if (count_q >= CW'(CAPACITY)) status_q <= ST_FULL;
					FUNC_REMOVE: if (count_q == '0) status_q <= ST_EMPTY;
					FUNC_UPDATE: if (count_q == '0) status_q <= ST_NOT_FOUND;
					default: ;
				endcase
			end
			S_UP_CMP: if (rd_prio > cur_prio_q) idx_q <= parent;
			S_RM_RD: begin
				onode_q <= rd_node;
				oprio_q <= rd_prio;
			end
			S_RM_LAST: begin
				cur_node_q <= rd_node;
				cur_prio_q <= rd_prio;
			end
			S_DN_LEFT: begin
				if (rd_prio < cur_prio_q) begin
					bnode_q <= rd_node;
					bprio_q <= rd_prio;
					bsel_q  <= 1'b1;
				end else begin
					bnode_q <= cur_node_q;
					bprio_q <= cur_prio_q;
					bsel_q  <= 1'b0;
				end
				if (!has_right && rd_prio < cur_prio_q) idx_q <= lchild;
			end
			S_DN_RIGHT: begin
				if (rd_prio < bprio_q) idx_q <= rchild;
				else if (bsel_q) idx_q <= lchild;
			end
			S_FIND_CMP: begin
				if (hit) found_q <= 1'b1;
				else if (has_left) idx_q <= lchild;
			end
			S_FIND_UP: begin
				if (idx_q == '0) begin
					if (func_q == FUNC_UPDATE) status_q <= ST_NOT_FOUND;
				end else if (climb_next) begin
					idx_q <= sibling;
				end else begin
					idx_q <= parent;
				end
			end
			default: ;
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = (state_q == S_DONE);
	assign out_node_id  = onode_q;
	assign out_priority = oprio_q;
	assign found        = found_q;
	assign status       = status_q;
	assign occupancy    = OCC_W'(count_q);

`ifndef SYNTHESIS
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY)) else $error("count over capacity");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_full_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q == ST_FULL) |-> $stable(count_q)) else $error("full changed count");
`endif

endmodule

FILE: tb/tb_min_heap_priority_queue_core.sv
`timescale 1ns / 100ps

module tb_min_heap_priority_queue_core;
	import mhpq_pkg::*;

	localparam int CAP = 256;
	localparam int CYCLE_LIMIT = 5000000;

	typedef struct {
		func_t             op;
		logic [NODE_W-1:0] id;
		logic [PRIO_W-1:0] prio;
	} heap_op_t;

	typedef struct {
		logic [NODE_W-1:0] node;
		logic [PRIO_W-1:0] prio;
		logic              hit;
		status_t           st;
		logic [OCC_W-1:0]  occ;
	} heap_resp_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        func;
	logic [NODE_W-1:0] node_id;
	logic [PRIO_W-1:0] priority_req;
	logic              done;
	logic [NODE_W-1:0] out_node_id;
	logic [PRIO_W-1:0] out_priority;
	logic              found;
	logic [1:0]        status;
	logic [OCC_W-1:0]  occupancy;

	min_heap_priority_queue_core #(.CAPACITY(CAP)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.node_id(node_id), .priority_req(priority_req), .done(done),
		.out_node_id(out_node_id), .out_priority(out_priority), .found(found),
		.status(status), .occupancy(occupancy)
	);

	heap_op_t   op_queue[$];
	heap_resp_t pending_resp[$];
	heap_op_t   cur_op;
	int         errors = 0;
	int         cycles = 0;
	int         gap = 0;
	bit         running = 0;

	// shadow heap
	logic [NODE_W-1:0] shadow_node[CAP];
	logic [PRIO_W-1:0] shadow_prio[CAP];
	int                shadow_cnt = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void swap_pair(input int a, input int b);
		logic [NODE_W-1:0] tn;
		logic [PRIO_W-1:0] tp;
		tn = shadow_node[a]; shadow_node[a] = shadow_node[b]; shadow_node[b] = tn;
		tp = shadow_prio[a]; shadow_prio[a] = shadow_prio[b]; shadow_prio[b] = tp;
	endfunction

	function automatic void sift_up(input int i);
		int p;
		while (i > 0 && i < shadow_cnt) begin
			p = (i - 1) / 2;
			if (shadow_prio[p] <= shadow_prio[i])
				break;
			swap_pair(p, i);
			i = p;
		end
	endfunction

	function automatic void sift_down(input int i);
		int best;
		while (i < shadow_cnt) begin
			best = i;
			if (2*i+1 < shadow_cnt && shadow_prio[2*i+1] < shadow_prio[best])
				best = 2*i+1;
			if (2*i+2 < shadow_cnt && shadow_prio[2*i+2] < shadow_prio[best])
				best = 2*i+2;
			if (best == i)
				break;
			swap_pair(best, i);
			i = best;
		end
	endfunction

	// pre-order walk, first match wins
	function automatic int locate(input logic [NODE_W-1:0] id);
		int i;
		i = 0;
		if (shadow_cnt == 0)
			return -1;
		forever begin
			if (shadow_node[i] == id)
				return i;
			if (2*i+1 < shadow_cnt) begin
				i = 2*i+1;
				continue;
			end
			forever begin
				if (i == 0)
					return -1;
				if (i[0] && i + 1 < shadow_cnt) begin
					i = i + 1;
					break;
				end
				i = (i - 1) / 2;
			end
		end
	endfunction

	function automatic heap_resp_t apply_op(input heap_op_t t);
		heap_resp_t r;
		int pos;
		r = '{node: '0, prio: '0, hit: 1'b0, st: ST_OK, occ: '0};
		case (t.op)
			FUNC_INSERT: begin
				if (shadow_cnt >= CAP)
					r.st = ST_FULL;
				else begin
					shadow_node[shadow_cnt] = t.id;
					shadow_prio[shadow_cnt] = t.prio;
					shadow_cnt++;
					sift_up(shadow_cnt - 1);
				end
			end
			FUNC_REMOVE: begin
				if (shadow_cnt == 0)
					r.st = ST_EMPTY;
				else begin
					r.node = shadow_node[0];
					r.prio = shadow_prio[0];
					swap_pair(0, shadow_cnt - 1);
					shadow_cnt--;
					sift_down(0);
				end
			end
			FUNC_CONTAINS: r.hit = (locate(t.id) >= 0);
			default: begin
				pos = locate(t.id);
				if (pos >= 0) begin
					r.hit = 1'b1;
					shadow_prio[pos] = t.prio;
					sift_up(pos);
				end else
					r.st = ST_NOT_FOUND;
			end
		endcase
		r.occ = shadow_cnt[OCC_W-1:0];
		return r;
	endfunction

	function automatic void push_op(input func_t f, input logic [NODE_W-1:0] id,
			input logic [PRIO_W-1:0] p);
		op_queue = {op_queue, heap_op_t'{op: f, id: id, prio: p}};
	endfunction

	function automatic logic [NODE_W-1:0] rand_id();
		if ($urandom_range(0, 3) != 0)
			return NODE_W'($urandom_range(0, 47));
		return NODE_W'($urandom);
	endfunction

	function automatic logic [PRIO_W-1:0] rand_prio();
		if ($urandom_range(0, 1) != 0)
			return $urandom_range(0, 255);
		return $urandom;
	endfunction

	function automatic void push_mixed(input int n, input int ins_pct);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < ins_pct)
				push_op(FUNC_INSERT, rand_id(), rand_prio());
			else if (r < ins_pct + 25)
				push_op(FUNC_REMOVE, NODE_W'($urandom), $urandom);
			else if (r < ins_pct + 37)
				push_op(FUNC_CONTAINS, rand_id(), $urandom);
			else
				push_op(FUNC_UPDATE, rand_id(), rand_prio());
		end
	endfunction

	// driver: advance to the next transaction once the current one is taken
	always @(posedge clk) begin
		if (!running) begin
			start <= 1'b0;
			func <= FUNC_INSERT;
			node_id <= '0;
			priority_req <= '0;
		end else begin
			if (start && !busy)
				pending_resp = {pending_resp, apply_op(cur_op)};
			if (!start || !busy) begin
				if (gap > 0) begin
					gap--;
					start <= 1'b0;
				end else if (op_queue.size() == 0) begin
					start <= 1'b0;
				end else if (op_queue.size() > 100 && $urandom_range(0, 5) == 0) begin
					gap = $urandom_range(0, 16);
					start <= 1'b0;
				end else begin
					cur_op = op_queue.pop_front();
					func <= cur_op.op;
					node_id <= cur_op.id;
					priority_req <= cur_op.prio;
					start <= 1'b1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		heap_resp_t e;
		if (arst_n && done) begin
			if (pending_resp.size() == 0) begin
				report("unexpected result", 64'd0, 64'd0);
			end else begin
				e = pending_resp.pop_front();
				if (out_node_id !== e.node)
					report("out_node_id", 64'(out_node_id), 64'(e.node));
				if (out_priority !== e.prio)
					report("out_priority", 64'(out_priority), 64'(e.prio));
				if (found !== e.hit) report("found", 64'(found), 64'(e.hit));
				if (status !== e.st) report("status", 64'(status), 64'(e.st));
				if (occupancy !== e.occ)
					report("occupancy", 64'(occupancy), 64'(e.occ));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;

		// directed: empty cases, extremes, duplicates, ties, raised key
		push_op(FUNC_REMOVE, 24'hFFFFFF, 32'hFFFFFFFF);
		push_op(FUNC_CONTAINS, 24'd5, 32'd0);
		push_op(FUNC_UPDATE, 24'd5, 32'd9);
		push_op(FUNC_INSERT, 24'hFFFFFF, 32'hFFFFFFFF);
		push_op(FUNC_INSERT, 24'd0, 32'd0);
		push_op(FUNC_INSERT, 24'd5, 32'd100);
		push_op(FUNC_INSERT, 24'd5, 32'd50);
		push_op(FUNC_CONTAINS, 24'd5, 32'd0);
		push_op(FUNC_CONTAINS, 24'hFFFFFF, 32'd0);
		push_op(FUNC_CONTAINS, 24'hABCDEF, 32'd0);
		push_op(FUNC_UPDATE, 24'd5, 32'd200);
		push_op(FUNC_UPDATE, 24'd0, 32'hFFFFFFFF);
		push_op(FUNC_UPDATE, 24'hFFFFFF, 32'd0);
		push_op(FUNC_INSERT, 24'd7, 32'd100);
		push_op(FUNC_INSERT, 24'd8, 32'd100);
		push_op(FUNC_UPDATE, 24'h123456, 32'd1);
		repeat (8) push_op(FUNC_REMOVE, 24'd0, 32'd0);

		// random: mixed churn, fill past full, drain, more churn
		push_mixed(250, 55);
		repeat (270) push_op(FUNC_INSERT, rand_id(), rand_prio());
		push_mixed(40, 10);
		push_mixed(200, 5);
		repeat (80) push_op(FUNC_REMOVE, '0, '0);
		push_mixed(250, 45);
		push_mixed(250, 40);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		running <= 1'b1;
		@(posedge clk);
		while (op_queue.size() != 0 || start || pending_resp.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
